// ===== hdl/cmdg_pkg.sv =====
package cmdg_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam int CHAN_W      = 8;
  localparam int DIM_CFG_W   = 12;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [DIM_CFG_W-1:0] RST_IMAGE_WIDTH  = 12'd1280;
  localparam logic [DIM_CFG_W-1:0] RST_IMAGE_HEIGHT = 12'd1024;
  localparam logic [CHAN_W-1:0]    RST_COLOR_THRESHOLD      = 8'd80;
  localparam logic [CHAN_W-1:0]    RST_BRIGHTNESS_THRESHOLD = 8'd80;

  // BT.601 gray, 14-bit fixed point with rounding
  localparam int GRAY_SUM_W = 22;
  localparam int GRAY_SHIFT = 14;
  localparam logic [GRAY_SUM_W-1:0] GRAY_W_BLUE  = 22'd1868;
  localparam logic [GRAY_SUM_W-1:0] GRAY_W_GREEN = 22'd9617;
  localparam logic [GRAY_SUM_W-1:0] GRAY_W_RED   = 22'd4899;
  localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND   = 22'd8192;

  // 3x3 window: bit s*3+t, s = column slot (0 oldest), t = row (0 top)
  localparam int WIN_COL  = 3;
  localparam int WIN_BITS = 9;

  // line buffer word layout
  localparam int LB_W         = 3;
  localparam int LB_TWO_ABOVE = 0;
  localparam int LB_ABOVE     = 1;
  localparam int LB_GRAY      = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH          = 3'd0,
    REG_IMAGE_HEIGHT         = 3'd1,
    REG_COLOR_MODE           = 3'd2,
    REG_COLOR_THRESHOLD      = 3'd3,
    REG_BRIGHTNESS_THRESHOLD = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_DRAIN = 2'd1,
    KIND_FINAL = 2'd2
  } item_kind_t;

  typedef struct packed {
    item_kind_t            kind;
    logic                  color_bit;
    logic                  pre_shift;
    logic                  emit;
    logic [WIN_BITS-1:0]   win_mask;
    logic [CHAN_W-1:0]     blue;
    logic [CHAN_W-1:0]     green;
    logic [CHAN_W-1:0]     red;
  } work_t;

  function automatic logic [CHAN_W-1:0] gray_value(input logic [CHAN_W-1:0] b,
                                                   input logic [CHAN_W-1:0] g,
                                                   input logic [CHAN_W-1:0] r);
    logic [GRAY_SUM_W-1:0] sum;
    sum = GRAY_SUM_W'(b) * GRAY_W_BLUE + GRAY_SUM_W'(g) * GRAY_W_GREEN
        + GRAY_SUM_W'(r) * GRAY_W_RED + GRAY_ROUND;
    return sum[GRAY_SUM_W-1:GRAY_SHIFT];
  endfunction

  function automatic logic [WIN_BITS-1:0] window_mask(input logic [1:0] lo,
                                                      input logic [1:0] hi,
                                                      input logic top_ok,
                                                      input logic bot_ok);
    logic [WIN_BITS-1:0] m;
    m = '0;
    for (int s = 0; s < WIN_COL; s++) begin
      for (int t = 0; t < WIN_COL; t++) begin
        m[s*WIN_COL+t] = (2'(s) >= lo) && (2'(s) <= hi) &&
                         (t != 0 || top_ok) && (t != WIN_COL-1 || bot_ok);
      end
    end
    return m;
  endfunction

endpackage

// ===== hdl/color_mask_dilate_gray_gate_unit.sv =====
// Color-difference mask with 3x3 dilation and brightness gate.
// Input channel (in_valid/in_ready): BGR pixels in raster order, op = 0;
// after the last pixel of a frame, send drain items (op = 1) to flush the
// final row and pixel. A drain before the frame is complete is dropped.
// Output channel (out_valid/out_ready): one mask bit per image pixel, in
// raster order, frame_end set on the last pixel of the frame.
// Output pixel k of a frame leaves with input item k + W + 1 (W = width),
// so a frame needs W + 1 drain items; the frame_end result returns the
// position to the start of a new frame.
// An item taken into the queue passes the queue and the back end stage
// register before its result is registered. Throughput: one item per clock
// unless out_ready stalls, set by the line buffer RAM's single port pair (one read, one write per item).
// A four-entry queue parts the classifying front end from the line buffer
// back end; while a result waits on out_ready the back end freezes and the
// queue keeps taking input until it fills, then in_ready drops.
// cfg_write stores cfg_data into register cfg_index; write only when idle.
// Reset (rst, synchronous) restores the register defaults and the frame
// position; line buffer contents are not cleared and need no clearing.
module color_mask_dilate_gray_gate_unit import cmdg_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   op,
  input  logic [CHAN_W-1:0]      blue,
  input  logic [CHAN_W-1:0]      green,
  input  logic [CHAN_W-1:0]      red,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   mask_bit,
  output logic                   frame_end
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [DIM_CFG_W-1:0] image_width, image_height;
  logic                 color_mode;
  logic [CHAN_W-1:0]    color_threshold, brightness_threshold;

  logic             q_full, push, q_valid, q_pop;
  work_t            push_work, q_work;
  logic [COL_W-1:0] push_col, q_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width          <= RST_IMAGE_WIDTH;
      image_height         <= RST_IMAGE_HEIGHT;
      color_mode           <= 1'b0;
      color_threshold      <= RST_COLOR_THRESHOLD;
      brightness_threshold <= RST_BRIGHTNESS_THRESHOLD;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:          image_width          <= cfg_data[DIM_CFG_W-1:0];
        REG_IMAGE_HEIGHT:         image_height         <= cfg_data[DIM_CFG_W-1:0];
        REG_COLOR_MODE:           color_mode           <= cfg_data[0];
        REG_COLOR_THRESHOLD:      color_threshold      <= cfg_data[CHAN_W-1:0];
        REG_BRIGHTNESS_THRESHOLD: brightness_threshold <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  cmdg_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .blue            (blue),
    .green           (green),
    .red             (red),
    .image_width     (image_width),
    .image_height    (image_height),
    .color_mode      (color_mode),
    .color_threshold (color_threshold),
    .q_full          (q_full),
    .push            (push),
    .push_work       (push_work),
    .push_col        (push_col)
  );

  cmdg_queue #(
    .DEPTH (QUEUE_DEPTH),
    .COL_W (COL_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_work  (push_work),
    .push_col   (push_col),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_work  (q_work),
    .head_col   (q_col)
  );

  cmdg_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk                  (clk),
    .rst                  (rst),
    .q_valid              (q_valid),
    .q_work               (q_work),
    .q_col                (q_col),
    .q_pop                (q_pop),
    .brightness_threshold (brightness_threshold),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .mask_bit             (mask_bit),
    .frame_end            (frame_end)
  );

endmodule

// ===== hdl/cmdg_ram.sv =====
module cmdg_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/cmdg_front.sv =====
module cmdg_front import cmdg_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic [CHAN_W-1:0]    blue,
  input  logic [CHAN_W-1:0]    green,
  input  logic [CHAN_W-1:0]    red,
  input  logic [DIM_CFG_W-1:0] image_width,
  input  logic [DIM_CFG_W-1:0] image_height,
  input  logic                 color_mode,
  input  logic [CHAN_W-1:0]    color_threshold,
  input  logic                 q_full,
  output logic                 push,
  output work_t                push_work,
  output logic [COL_W-1:0]     push_col
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int WC_W  = (WW > DIM_CFG_W) ? WW : DIM_CFG_W;
  localparam int HC_W  = (ROW_W > DIM_CFG_W) ? ROW_W : DIM_CFG_W;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  logic [WW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [WW-1:0]    col_w;
  logic             accept, ignored, is_pixel, is_drain, is_final;
  logic             col_zero, col_wrap;
  logic             row_ge2, row_ge3, row_lt_h;
  logic [1:0]       lo, hi;
  logic             top_ok, bot_ok, emit, pre_shift;
  logic [CHAN_W-1:0] diff;

  always_comb begin
    if (image_width == '0) begin
      w_eff = WW'(1);
    end else if (WC_W'(image_width) > WC_W'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = ROW_W'(1);
    end else if (HC_W'(image_height) > HC_W'(MAX_HEIGHT)) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_W'(image_height);
    end
  end

  assign row_lt_h = row < h_eff;
  assign is_pixel = row_lt_h && !op;
  assign ignored  = row_lt_h && op;     // drain before the frame is complete
  assign is_drain = row == h_eff;
  assign is_final = row > h_eff;

  assign col_w    = WW'(col);
  assign col_zero = col == '0;
  assign col_wrap = (col_w + WW'(1)) >= w_eff;
  assign row_ge2  = row >= ROW_W'(2);
  assign row_ge3  = row >= ROW_W'(3);

  // column 0 and the frame end emit the last pixel of the row two back
  // before the window shifts; other columns emit after it
  always_comb begin
    if (is_final || col_zero) begin
      lo        = (w_eff >= WW'(2)) ? 2'd1 : 2'd2;
      hi        = 2'd2;
      top_ok    = row_ge3;
      bot_ok    = row <= h_eff;
      emit      = is_final || row_ge2;
      pre_shift = 1'b1;
    end else begin
      lo        = (col > COL_W'(1)) ? 2'd0 : 2'd1;
      hi        = (col_w < w_eff) ? 2'd2 : 2'd1;
      top_ok    = row_ge2;
      bot_ok    = row_lt_h;
      emit      = row != '0;
      pre_shift = 1'b0;
    end
  end

  always_comb begin
    if (color_mode) begin
      diff = (red > blue) ? red - blue : '0;
    end else begin
      diff = (blue > red) ? blue - red : '0;
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && !ignored;

  always_comb begin
    if (is_final) begin
      push_work.kind = KIND_FINAL;
    end else if (is_drain) begin
      push_work.kind = KIND_DRAIN;
    end else begin
      push_work.kind = KIND_PIXEL;
    end
    push_work.color_bit = is_pixel && (diff > color_threshold);
    push_work.pre_shift = pre_shift;
    push_work.emit      = emit;
    push_work.win_mask  = window_mask(lo, hi, top_ok, bot_ok);
    push_work.blue      = blue;
    push_work.green     = green;
    push_work.red       = red;
  end

  assign push_col = col;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (push) begin
      if (is_final) begin
        col <= '0;
        row <= '0;
      end else if (col_wrap) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

endmodule

// ===== hdl/cmdg_queue.sv =====
module cmdg_queue import cmdg_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH,
  parameter int COL_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  work_t            push_work,
  input  logic [COL_W-1:0] push_col,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output work_t            head_work,
  output logic [COL_W-1:0] head_col
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t            work_mem [DEPTH];
  logic [COL_W-1:0] col_mem  [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_work  = work_mem[rd_ptr];
  assign head_col   = col_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      work_mem[wr_ptr] <= push_work;
      col_mem[wr_ptr]  <= push_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/cmdg_back.sv =====
module cmdg_back import cmdg_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  work_t             q_work,
  input  logic [COL_W-1:0]  q_col,
  output logic              q_pop,
  input  logic [CHAN_W-1:0] brightness_threshold,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              mask_bit,
  output logic              frame_end
);

  logic                advance, fire;
  logic                b_valid;
  work_t               b_work;
  logic [COL_W-1:0]    b_col;
  logic [CHAN_W-1:0]   b_gray;
  logic                fwd_hit;
  logic [LB_W-1:0]     fwd_data;
  logic [LB_W-1:0]     ram_q, lb, wr_data;
  logic                wr_en;
  logic [WIN_BITS-1:0] window, shifted, src;
  logic [WIN_COL-1:0]  colvec;
  logic                gray_hold, result, is_pixel;

  // whole back end moves when the output register can take a result
  assign advance = !out_valid || out_ready;
  assign q_pop   = advance && q_valid;
  assign fire    = advance && b_valid;

  cmdg_ram #(
    .WIDTH (LB_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (q_pop),
    .rd_addr (q_col),
    .rd_data (ram_q),
    .wr_en   (wr_en),
    .wr_addr (b_col),
    .wr_data (wr_data)
  );

  // same column read while the previous item writes it: take the new word
  assign lb       = fwd_hit ? fwd_data : ram_q;
  assign is_pixel = b_work.kind == KIND_PIXEL;

  always_comb begin
    colvec = '0;
    colvec[0] = lb[LB_TWO_ABOVE];
    colvec[1] = lb[LB_ABOVE];
    colvec[2] = is_pixel && b_work.color_bit;
    shifted = {colvec, window[WIN_BITS-1:WIN_COL]};
    src     = b_work.pre_shift ? window : shifted;
    result  = (|(src & b_work.win_mask)) && gray_hold;

    wr_data = '0;
    wr_data[LB_TWO_ABOVE] = lb[LB_ABOVE];
    wr_data[LB_ABOVE]     = b_work.color_bit;
    wr_data[LB_GRAY]      = b_gray > brightness_threshold;
  end

  assign wr_en = fire && is_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      fwd_hit   <= 1'b0;
      window    <= '0;
      gray_hold <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        b_valid <= q_valid;
        fwd_hit <= wr_en && (q_col == b_col);
      end
      if (fire && b_work.kind != KIND_FINAL) begin
        window    <= shifted;
        gray_hold <= lb[LB_GRAY];
      end
      if (fire && b_work.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_work   <= q_work;
      b_col    <= q_col;
      b_gray   <= gray_value(q_work.blue, q_work.green, q_work.red);
      fwd_data <= wr_data;
    end
    if (fire && b_work.emit) begin
      mask_bit  <= result;
      frame_end <= b_work.kind == KIND_FINAL;
    end
  end

endmodule

// ===== hdl/cmdg_checker.sv =====
module cmdg_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic mask_bit,
  input logic frame_end
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mask_bit) && $stable(frame_end))
    else $error("output transaction changed while stalled");

  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // queue is empty after reset
  a_rst_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  // the queue fills only through an accepted input transaction
  a_ready_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("in_ready dropped without an input transaction");

endmodule

bind color_mask_dilate_gray_gate_unit cmdg_checker u_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import cmdg_pkg::*;

  localparam int LINE_MAX      = MAX_WIDTH_DEF;
  localparam int ROWS_MAX      = MAX_HEIGHT_DEF;
  localparam int STUCK_LIMIT   = 5000;
  localparam int LONG_STALL    = 300;
  localparam int TOTAL_ITEMS   = 1700;
  localparam int SETTLE_CYCLES = 6;
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic              op;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } bgr_item_t;

  typedef struct packed {
    logic mask_bit;
    logic frame_end;
  } mask_pixel_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   op = OP_PIXEL;
  logic [CHAN_W-1:0]      blue = '0;
  logic [CHAN_W-1:0]      green = '0;
  logic [CHAN_W-1:0]      red = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   mask_bit;
  logic                   frame_end;

  color_mask_dilate_gray_gate_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .blue      (blue),
    .green     (green),
    .red       (red),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mask_bit  (mask_bit),
    .frame_end (frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // register copies
  logic [DIM_CFG_W-1:0] width_cfg  = RST_IMAGE_WIDTH;
  logic [DIM_CFG_W-1:0] height_cfg = RST_IMAGE_HEIGHT;
  logic                 mode_cfg   = 1'b0;
  logic [CHAN_W-1:0]    color_thr  = RST_COLOR_THRESHOLD;
  logic [CHAN_W-1:0]    bright_thr = RST_BRIGHTNESS_THRESHOLD;

  // predictor state
  bit                  color_above     [LINE_MAX];
  bit                  color_two_above [LINE_MAX];
  bit                  gray_row_dly    [LINE_MAX];
  logic [WIN_BITS-1:0] color_win = '0;
  int                  col_pos = 0;
  int                  row_pos = 0;
  bit                  gray_hold = 1'b0;

  bgr_item_t   pending_items[$];
  mask_pixel_t expected_pixels[$];
  bgr_item_t   next_item;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int stall_requests  = 0;
  int stall_taken     = 0;
  int stall_left      = 0;
  int mismatch_count  = 0;
  int stuck_cycles    = 0;
  int items_queued    = 0;

  function automatic void add_item(bgr_item_t it);
    pending_items.insert(pending_items.size(), it);
    items_queued++;
  endfunction

  function automatic void add_expected(mask_pixel_t px);
    expected_pixels.insert(expected_pixels.size(), px);
  endfunction

  function automatic int clamp_dim(logic [DIM_CFG_W-1:0] v, int top);
    if (v == 0) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  function automatic bit window_or(int lo, int hi, bit top_ok, bit bot_ok);
    bit acc;
    acc = 1'b0;
    for (int s = lo; s <= hi; s++)
      for (int t = 0; t < 3; t++)
        if ((t != 0 || top_ok) && (t != 2 || bot_ok)) acc |= color_win[s*3+t];
    return acc;
  endfunction

  // one accepted item -> zero or one expected mask pixel
  function automatic void predict_mask(logic op_in, logic [CHAN_W-1:0] b,
                                       logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] r);
    int       w, h, row, col, diff, gray;
    bit       cb, gb, out_gray, emit, m;
    logic [2:0] colvec;
    w = clamp_dim(width_cfg, LINE_MAX);
    h = clamp_dim(height_cfg, ROWS_MAX);
    row = row_pos;
    col = col_pos;
    emit = 1'b0;
    m = 1'b0;
    if (col >= LINE_MAX) col = 0;

    if (row < h) begin
      if (op_in == OP_DRAIN) return;
      if (mode_cfg) diff = (r > b) ? int'(r) - int'(b) : 0;
      else diff = (b > r) ? int'(b) - int'(r) : 0;
      cb = diff > int'(color_thr);
      gray = (1868 * int'(b) + 9617 * int'(g) + 4899 * int'(r) + 8192) >> 14;
      gb = gray > int'(bright_thr);
      colvec = {cb, color_above[col], color_two_above[col]};
      color_two_above[col] = color_above[col];
      color_above[col] = cb;
      out_gray = gray_hold;
      gray_hold = gray_row_dly[col];
      gray_row_dly[col] = gb;
    end else if (row >= h + 1) begin
      // last pixel of the frame, then back to the start
      m = window_or(w >= 2 ? 1 : 2, 2, row >= 3, row - 1 < h);
      add_expected('{m & gray_hold, 1'b1});
      col_pos = 0;
      row_pos = 0;
      return;
    end else begin
      colvec = {1'b0, color_above[col], color_two_above[col]};
      out_gray = gray_hold;
      gray_hold = gray_row_dly[col];
    end

    if (col == 0) begin
      // right edge of the row two back, from the old window
      if (row >= 2) begin
        m = window_or(w >= 2 ? 1 : 2, 2, row >= 3, row - 1 < h);
        emit = 1'b1;
      end
      color_win = {colvec, color_win[WIN_BITS-1:3]};
    end else begin
      color_win = {colvec, color_win[WIN_BITS-1:3]};
      if (row >= 1) begin
        m = window_or(col >= 2 ? 0 : 1, col < w ? 2 : 1, row >= 2, row < h);
        emit = 1'b1;
      end
    end

    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos = row + 1;
    end else begin
      col_pos = col + 1;
    end

    if (emit) add_expected('{m & out_gray, 1'b0});
  endfunction

  function automatic bgr_item_t random_item(logic op_in);
    bgr_item_t it;
    int d, lo;
    it.op = op_in;
    it.green = CHAN_W'($urandom_range(255));
    it.blue = CHAN_W'($urandom_range(255));
    it.red = CHAN_W'($urandom_range(255));
    case ($urandom_range(3))
      0: begin
        it.blue = CHAN_W'($urandom_range(1) * 255);
        it.green = CHAN_W'($urandom_range(1) * 255);
        it.red = CHAN_W'($urandom_range(1) * 255);
      end
      1: begin
        // difference right at the color threshold or one above
        d = int'(color_thr) + $urandom_range(1);
        if (d > 255) d = 255;
        lo = $urandom_range(255 - d);
        if (mode_cfg) begin
          it.red = CHAN_W'(lo + d);
          it.blue = CHAN_W'(lo);
        end else begin
          it.blue = CHAN_W'(lo + d);
          it.red = CHAN_W'(lo);
        end
      end
      default: ;
    endcase
    return it;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_mask(op, blue, green, red);
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_item = pending_items.pop_front();
          in_valid <= 1'b1;
          op <= next_item.op;
          blue <= next_item.blue;
          green <= next_item.green;
          red <= next_item.red;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    mask_pixel_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected transaction mask_bit=%0b frame_end=%0b",
                   $time, mask_bit, frame_end);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (mask_bit !== want.mask_bit) begin
            $display("%0t: mask_bit expected %0b actual %0b", $time, want.mask_bit, mask_bit);
            mismatch_count++;
          end
          if (frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %0b actual %0b",
                     $time, want.frame_end, frame_end);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (stall_taken != stall_requests) begin
        stall_taken = stall_requests;
        stall_left = LONG_STALL;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input int val);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_IMAGE_WIDTH:          width_cfg = data;
      REG_IMAGE_HEIGHT:         height_cfg = data;
      REG_COLOR_MODE:           mode_cfg = data[0];
      REG_COLOR_THRESHOLD:      color_thr = data[CHAN_W-1:0];
      REG_BRIGHTNESS_THRESHOLD: bright_thr = data[CHAN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_config(input int w, input int h, input int mode, input int cthr,
                            input int bthr);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_COLOR_MODE, mode);
    write_reg(REG_COLOR_THRESHOLD, cthr);
    write_reg(REG_BRIGHTNESS_THRESHOLD, bthr);
  endtask

  // sampled at the falling edge so driver updates have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() > 0 || in_valid || expected_pixels.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_frame();
    int w, h;
    w = clamp_dim(width_cfg, LINE_MAX);
    h = clamp_dim(height_cfg, ROWS_MAX);
    for (int k = 0; k < w * h; k++) begin
      // drain before the frame is complete: dropped
      if ($urandom_range(49) == 0) add_item(random_item(OP_DRAIN));
      add_item(random_item(OP_PIXEL));
    end
    // pixels sent after the last one act as drains
    for (int k = 0; k <= w; k++)
      add_item(random_item($urandom_range(4) == 0 ? OP_PIXEL : OP_DRAIN));
    if ($urandom_range(3) == 0) add_item(random_item(OP_DRAIN));
  endtask

  initial begin
    int phase, w, h;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // 3x3 frame with channel extremes, zero thresholds
    set_config(3, 3, 0, 0, 0);
    add_item('{OP_DRAIN, 8'd0, 8'd0, 8'd0});
    add_item('{OP_PIXEL, 8'd0, 8'd0, 8'd0});
    add_item('{OP_PIXEL, 8'd255, 8'd255, 8'd255});
    add_item('{OP_PIXEL, 8'd255, 8'd0, 8'd0});
    add_item('{OP_PIXEL, 8'd0, 8'd0, 8'd255});
    add_item('{OP_DRAIN, 8'd255, 8'd255, 8'd255});
    add_item('{OP_PIXEL, 8'd0, 8'd255, 8'd0});
    add_item('{OP_PIXEL, 8'd1, 8'd0, 8'd0});
    add_item('{OP_PIXEL, 8'd255, 8'd0, 8'd255});
    add_item('{OP_PIXEL, 8'd0, 8'd255, 8'd255});
    add_item('{OP_PIXEL, 8'd255, 8'd255, 8'd0});
    add_item('{OP_DRAIN, 8'd0, 8'd0, 8'd0});
    add_item('{OP_PIXEL, 8'd255, 8'd0, 8'd0});
    add_item('{OP_DRAIN, 8'd0, 8'd0, 8'd0});
    add_item('{OP_DRAIN, 8'd0, 8'd0, 8'd0});
    add_item('{OP_DRAIN, 8'd0, 8'd0, 8'd0});
    add_item('{OP_DRAIN, 8'd0, 8'd0, 8'd0});
    wait_idle();

    // zero size acts as 1x1; first drain gives nothing
    set_config(0, 0, 1, 255, 255);
    add_item('{OP_PIXEL, 8'd0, 8'd255, 8'd255});
    add_item('{OP_DRAIN, 8'd0, 8'd0, 8'd0});
    add_item('{OP_DRAIN, 8'd0, 8'd0, 8'd0});
    wait_idle();

    // height cut below the current row while the frame is open
    set_config(4, 4, 1, 10, 20);
    for (int k = 0; k < 8; k++) add_item(random_item(OP_PIXEL));
    wait_idle();
    write_reg(REG_IMAGE_HEIGHT, 1);
    add_item(random_item(OP_DRAIN));
    add_item(random_item(OP_DRAIN));
    wait_idle();

    phase = 0;
    while (items_queued < TOTAL_ITEMS) begin
      case (phase % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin sender_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      if (phase == 2) begin
        w = 20;
        h = 4;
      end else if ($urandom_range(9) == 0) begin
        w = $urandom_range(13, 64);
        h = $urandom_range(1, 4);
      end else begin
        w = $urandom_range(12);
        h = $urandom_range(8);
      end
      set_config(w, h, $urandom_range(1) | ($urandom_range(2047) << 1),
                 $urandom_range(255) | ($urandom_range(15) << 8),
                 $urandom_range(255) | ($urandom_range(15) << 8));
      // long receiver hold-off while the sender keeps offering
      if (phase == 2) stall_requests++;
      queue_frame();
      wait_idle();
      phase++;
    end

    wait_idle();
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
